// ----- rtl/kbd_fifo_pkg.sv -----
// Package for the keyboard event FIFO device: host command codes,
// key space size and the controller state type.
// No dependencies; used by the top level and its checker.
`default_nettype none

package kbd_fifo_pkg;

    localparam int unsigned KEY_W     = 8;
    localparam int unsigned KEY_SPACE = 256;
    localparam int unsigned REG_W     = 16;

    localparam logic [REG_W-1:0] CMD_CLEAR   = 16'd0;
    localparam logic [REG_W-1:0] CMD_POP     = 16'd1;
    localparam logic [REG_W-1:0] CMD_TEST    = 16'd2;
    localparam logic [REG_W-1:0] CMD_SET_MSG = 16'd3;

    localparam logic OP_KEY_EVENT = 1'b0;
    localparam logic OP_HOST_CMD  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/keyboard_event_fifo_device_top.sv -----
// Keyboard event FIFO device: key ring and pressed-key memories with the
// host command decoder. Depends on kbd_fifo_pkg.
//
// Result: an item accepted at a clock edge shows its result (done high) in
//   the cycle after that edge; the reply data come from the registered
//   read of the ring and pressed-key memories.
// Busy is high while the result shows; no new item is taken then.
// Reset: asynchronous, active low; indices, message and all pressed bits
//   clear at once (per-key valid flops), ring contents are left as they are.
// The receiver cannot stall: done lasts exactly one cycle.
`default_nettype none

module keyboard_event_fifo_device_top #(
    parameter int unsigned RING_DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               operation,
    input  wire logic [kbd_fifo_pkg::KEY_W-1:0]     key_code,
    input  wire logic                               key_down,
    input  wire logic [kbd_fifo_pkg::REG_W-1:0]     command,
    input  wire logic [kbd_fifo_pkg::REG_W-1:0]     argument,
    output logic                                    done,
    output logic                                    reply_valid,
    output logic [kbd_fifo_pkg::REG_W-1:0]          reply_value,
    output logic                                    raise_interrupt,
    output logic [kbd_fifo_pkg::REG_W-1:0]          interrupt_message
);
    import kbd_fifo_pkg::*;

    localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    // storage
    logic [KEY_W-1:0] ring_mem [RING_DEPTH];
    logic             pressed_mem [KEY_SPACE];
    logic [KEY_SPACE-1:0] pressed_vld_reg;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [REG_W-1:0] msg_reg, msg_next;

    // per-item decode, captured at accept
    logic             pop_cmd_reg, test_cmd_reg, pop_hit_reg;
    logic             test_ok_reg, irq_reg;
    logic [REG_W-1:0] irq_msg_reg;

    logic [KEY_W-1:0] ring_rdata_reg;
    logic             pressed_rdata_reg;

    logic             accept;
    logic             key_evt, is_pop, is_test, ring_push, ring_nonempty;
    logic [KEY_W-1:0] test_key;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_LAST)
            r = '0;
        else
            r = idx + IDX_W'(1);
        return r;
    endfunction

    assign accept        = start && (state_reg == ST_IDLE);
    assign key_evt       = (operation == OP_KEY_EVENT);
    assign is_pop        = (operation == OP_HOST_CMD) && (command == CMD_POP);
    assign is_test       = (operation == OP_HOST_CMD) && (command == CMD_TEST);
    assign ring_push     = key_evt && key_down && (key_code != '0);
    assign ring_nonempty = (wr_idx_reg != rd_idx_reg);
    assign test_key      = argument[KEY_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        msg_next    = msg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                    if (key_evt)
                    begin
                        if (ring_push)
                            wr_idx_next = idx_inc(wr_idx_reg);
                    end
                    else
                    begin
                        case (command)
                            CMD_CLEAR:   wr_idx_next = rd_idx_reg;
                            CMD_POP:
                            begin
                                if (ring_nonempty)
                                    rd_idx_next = idx_inc(rd_idx_reg);
                            end
                            CMD_SET_MSG: msg_next = argument;
                            default:     ;
                        endcase
                    end
                end
            end
            ST_EXEC:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wr_idx_reg      <= '0;
            rd_idx_reg      <= '0;
            msg_reg         <= '0;
            pressed_vld_reg <= '0;
            pop_cmd_reg     <= 1'b0;
            test_cmd_reg    <= 1'b0;
            pop_hit_reg     <= 1'b0;
            test_ok_reg     <= 1'b0;
            irq_reg         <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            msg_reg    <= msg_next;
            if (accept)
            begin
                if (key_evt)
                    pressed_vld_reg[key_code] <= 1'b1;
                pop_cmd_reg  <= is_pop;
                test_cmd_reg <= is_test;
                pop_hit_reg  <= is_pop && ring_nonempty;
                // keys beyond the key space always test as released
                test_ok_reg  <= (argument[REG_W-1:KEY_W] == '0) && pressed_vld_reg[test_key];
                irq_reg      <= key_evt && (msg_reg != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            irq_msg_reg <= msg_reg;
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && ring_push)
            ring_mem[wr_idx_reg] <= key_code;
        ring_rdata_reg <= ring_mem[rd_idx_reg];
    end

    // pressed-key memory; an entry never written reads as released
    always_ff @(posedge clk)
    begin
        if (accept && key_evt)
            pressed_mem[key_code] <= key_down;
        pressed_rdata_reg <= pressed_mem[test_key];
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = (state_reg == ST_EXEC);

    always_comb
    begin
        reply_valid       = done && (pop_cmd_reg || test_cmd_reg);
        reply_value       = '0;
        raise_interrupt   = done && irq_reg;
        interrupt_message = '0;
        if (done && pop_hit_reg)
            reply_value = {{(REG_W-KEY_W){1'b0}}, ring_rdata_reg};
        else if (done && test_cmd_reg)
            reply_value = {{(REG_W-1){1'b0}}, test_ok_reg && pressed_rdata_reg};
        if (done && irq_reg)
            interrupt_message = irq_msg_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/kbd_fifo_chk.sv -----
// Port-level checker for the keyboard event FIFO device, and its bind.
// Depends on kbd_fifo_pkg.
`default_nettype none

module kbd_fifo_chk (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic                           operation,
    input  wire logic [kbd_fifo_pkg::REG_W-1:0] command,
    input  wire logic                           done,
    input  wire logic                           reply_valid,
    input  wire logic [kbd_fifo_pkg::REG_W-1:0] reply_value,
    input  wire logic                           raise_interrupt,
    input  wire logic [kbd_fifo_pkg::REG_W-1:0] interrupt_message
);
    import kbd_fifo_pkg::*;

    // every accepted item gives exactly one result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done && !$past(done))
        else $error("no result after accepted item");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result shown for more than one cycle");

    // pop and test always reply; key events never do
    a_reply_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_HOST_CMD)
        && (command == CMD_POP || command == CMD_TEST) |=> reply_valid)
        else $error("pop or test gave no reply");

    a_key_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_KEY_EVENT) |=> !reply_valid && reply_value == '0)
        else $error("key event gave a reply");

    a_irq_msg: assert property (@(posedge clk) disable iff (!rst_n)
        raise_interrupt |-> done && interrupt_message != '0)
        else $error("interrupt without message");

endmodule

bind keyboard_event_fifo_device_top kbd_fifo_chk u_kbd_fifo_chk (.*);

`default_nettype wire
